### rtl/core/cuvp_pkg.sv
// Shared types and constants for the cylindrical UV projection core.
`default_nettype none
package cuvp_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_PROJ   = 3'd1;
	localparam logic [2:0] ST_NO_POS    = 3'd2;
	localparam logic [2:0] ST_NO_NORM   = 3'd3;
	localparam logic [2:0] ST_FACING    = 3'd4;

	localparam logic [1:0] REG_PROJ_VALID   = 2'd0;
	localparam logic [1:0] REG_ALLOW_IN     = 2'd1;
	localparam logic [1:0] REG_ALLOW_OUT    = 2'd2;
	localparam logic [1:0] REG_MASK_OUTSIDE = 2'd3;

	localparam int CW = 58;
	localparam int AW = 34;
	localparam int TABLE_LEN = 30;

	localparam logic [31:0] TURN_TABLE [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef struct packed {
		logic [2:0]         status;
		logic               zero;
		logic               z_nonneg;
		logic               mask;
		logic signed [31:0] py;
	} side_t;

endpackage
`default_nettype wire

### rtl/core/cylindrical_uv_projection_core.sv
// Cylindrical UV projection core: facing checks, CORDIC angle pipeline and output mapping.
// A request is taken in every cycle that start is high; busy is always low. Each request
// yields exactly one result, marked by done, after it has passed through one input
// stage that also forms the facing products, one stage per CORDIC iteration, and one
// output stage for rounding, offset and masking. The receiver cannot stall the block.
`default_nettype none
module cylindrical_uv_projection_core import cuvp_pkg::*; #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 18
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [17:0] norm_x,
	input  wire logic signed [17:0] norm_z,
	input  wire logic               entering,
	input  wire logic               pos_ok,
	input  wire logic               norm_ok,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic               cfg_wdata,
	output logic                    done,
	output logic signed [31:0]      coord_u,
	output logic signed [31:0]      coord_v,
	output logic signed [31:0]      coord_w,
	output logic [2:0]              status
);

	localparam int N = CORDIC_STAGES;
	localparam int SH = 32 - FRAC_BITS;
	localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] HALF = ONE >>> 1;

	logic proj_valid_q, allow_in_q, allow_out_q, mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_valid_q <= 1'b0;
			allow_in_q   <= 1'b1;
			allow_out_q  <= 1'b1;
			mask_q       <= 1'b0;
		end else if (cfg_we && cfg_index[2] == 1'b0) begin
			case (cfg_index[1:0])
				REG_PROJ_VALID:   proj_valid_q <= cfg_wdata;
				REG_ALLOW_IN:     allow_in_q   <= cfg_wdata;
				REG_ALLOW_OUT:    allow_out_q  <= cfg_wdata;
				REG_MASK_OUTSIDE: mask_q       <= cfg_wdata;
				default:          mask_q       <= mask_q;
			endcase
		end
	end

	assign busy = 1'b0;

	// Input stage.
	logic               vld_s [1:N+1];
	logic signed [CW-1:0] cx_s [1:N+1];
	logic signed [CW-1:0] cy_s [1:N+1];
	logic signed [AW-1:0] ang_s [1:N+1];
	side_t              sb_s [1:N+1];
	logic signed [49:0] px_nx_s1, pz_nz_s1;
	logic               face_chk_s1, entering_s1, norm_ok_s1, allow_in_s1, allow_out_s1;

	logic [32:0] ax, az;
	logic [2:0]  pre_st;
	assign ax = pos_x[31] ? 33'(-{pos_x[31], pos_x}) : {1'b0, pos_x};
	assign az = pos_z[31] ? 33'(-{pos_z[31], pos_z}) : {1'b0, pos_z};

	always_comb begin
		if (!proj_valid_q) begin
			pre_st = ST_NO_PROJ;
		end else if (!pos_ok) begin
			pre_st = ST_NO_POS;
		end else begin
			pre_st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else begin
			vld_s[1] <= start;
		end
	end

	always_ff @(posedge clk) begin
		px_nx_s1     <= pos_x * norm_x;
		pz_nz_s1     <= pos_z * norm_z;
		face_chk_s1  <= (pre_st == ST_OK) && !(allow_in_q && allow_out_q);
		entering_s1  <= entering;
		norm_ok_s1   <= norm_ok;
		allow_in_s1  <= allow_in_q;
		allow_out_s1 <= allow_out_q;
		sb_s[1].status   <= pre_st;
		sb_s[1].zero     <= (pos_x == 32'sd0) && (pos_z == 32'sd0);
		sb_s[1].z_nonneg <= !pos_z[31];
		sb_s[1].mask     <= mask_q;
		sb_s[1].py       <= pos_y;
		if (pos_x[31]) begin
			cx_s[1]  <= CW'({az, 24'd0});
			cy_s[1]  <= CW'({ax, 24'd0});
			ang_s[1] <= AW'(34'sd1 <<< 30);
		end else begin
			cx_s[1]  <= CW'({ax, 24'd0});
			cy_s[1]  <= CW'({az, 24'd0});
			ang_s[1] <= '0;
		end
	end

	// Facing decision, merged into the first CORDIC stage.
	logic signed [50:0] dot, dot_dir;
	logic [2:0]         face_st;
	assign dot     = 51'(px_nx_s1) + 51'(pz_nz_s1);
	assign dot_dir = entering_s1 ? dot : -dot;

	always_comb begin
		face_st = sb_s[1].status;
		if (face_chk_s1) begin
			if (!norm_ok_s1) begin
				face_st = ST_NO_NORM;
			end else if ((!allow_in_s1 && dot_dir < 0) || (!allow_out_s1 && dot_dir > 0)) begin
				face_st = ST_FACING;
			end
		end
	end

	// CORDIC vectoring stages, one iteration each.
	for (genvar k = 1; k <= N; k++) begin : g_cordic
		localparam int I = k - 1;
		logic signed [AW-1:0] step;
		side_t                sb_nxt;
		assign step = AW'(TURN_TABLE[I]);

		always_comb begin
			sb_nxt = sb_s[k];
			if (k == 1) begin
				sb_nxt.status = face_st;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sb_s[k+1] <= sb_nxt;
			if (!cy_s[k][CW-1]) begin
				cx_s[k+1]  <= cx_s[k] + (cy_s[k] >>> I);
				cy_s[k+1]  <= cy_s[k] - (cx_s[k] >>> I);
				ang_s[k+1] <= ang_s[k] + step;
			end else begin
				cx_s[k+1]  <= cx_s[k] - (cy_s[k] >>> I);
				cy_s[k+1]  <= cy_s[k] + (cx_s[k] >>> I);
				ang_s[k+1] <= ang_s[k] - step;
			end
		end
	end

	// Output stage.
	logic signed [AW-1:0] ang_cl, ang_rnd;
	logic signed [31:0]   th, u_n, v_n, w_n;
	logic signed [32:0]   v_sum;
	side_t                sb_f;
	assign sb_f = sb_s[N+1];

	always_comb begin
		ang_cl = ang_s[N+1];
		if (ang_cl < 0) begin
			ang_cl = '0;
		end else if (ang_cl > (34'sd1 <<< 31)) begin
			ang_cl = 34'sd1 <<< 31;
		end
		ang_rnd = (ang_cl + (34'sd1 <<< (SH - 1))) >>> SH;
		th      = ang_rnd[31:0];
		v_sum   = 33'(sb_f.py) + 33'(HALF);
		if (sb_f.status != ST_OK) begin
			u_n = '0;
			v_n = '0;
			w_n = -ONE;
		end else begin
			if (sb_f.zero) begin
				u_n = '0;
				v_n = sb_f.py;
			end else begin
				u_n = sb_f.z_nonneg ? ONE - th : th;
				v_n = (v_sum > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF : v_sum[31:0];
			end
			w_n = '0;
			if (sb_f.mask) begin
				w_n = (u_n < 0 || u_n > ONE || v_n < 0 || v_n > ONE) ? -ONE : ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[N+1];
		end
	end

	always_ff @(posedge clk) begin
		coord_u <= u_n;
		coord_v <= v_n;
		coord_w <= w_n;
		status  <= sb_f.status;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(N+2) done) else $error("request did not produce a result");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> coord_u == 0 && coord_v == 0 && coord_w == -ONE)
		else $error("error result not cleared");
	a_no_mask_w: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N+1] && sb_f.status == ST_OK && !sb_f.mask |=> coord_w == 0)
		else $error("unmasked w not zero");
	a_u_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_OK |-> coord_u >= 0 && coord_u <= ONE)
		else $error("u outside unit range");

endmodule
`default_nettype wire
